FILE: hdl/adrs_pkg.sv
// Package for the alarm DTMF receiver sequencer: types, codes and reset values.
`default_nettype none

package adrs_pkg;

   // Register reset values and widths
   localparam logic [15:0] NUMBER_GAP_RESET     = 16'd1200;
   localparam logic [15:0] MESSAGE_GAP_RESET    = 16'd13000;
   localparam logic [9:0]  HANDSHAKE_TONE_RESET = 10'd100;
   localparam logic [9:0]  KISSOFF_PAUSE_RESET  = 10'd300;
   localparam logic [15:0] KISSOFF_RESET        = 16'd10000;

   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;

   localparam int DIGITS_PER_MESSAGE_DEFAULT = 16;
   localparam int MESSAGE_W = 64;

   // Decoder code that stands for digit zero
   localparam logic [3:0] DIGIT_ZERO_CODE = 4'd10;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NUMBER_GAP     = 3'd0,
      CSR_MESSAGE_GAP    = 3'd1,
      CSR_HANDSHAKE_TONE = 3'd2,
      CSR_KISSOFF_PAUSE  = 3'd3,
      CSR_KISSOFF        = 3'd4
   } csr_index_type;

   // Protocol stage
   typedef enum logic [1:0] {
      ST_LISTEN    = 2'd0,
      ST_HANDSHAKE = 2'd1,
      ST_COLLECT   = 2'd2,
      ST_BUSY_OUT  = 2'd3
   } stage_type;

   // Timed busy phase
   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_HS_LOW  = 3'd1,
      PH_HS_HIGH = 3'd2,
      PH_PAUSE   = 3'd3,
      PH_KISS    = 3'd4
   } phase_type;

   // Tone codes
   typedef enum logic [1:0] {
      TONE_SILENT = 2'd0,
      TONE_300    = 2'd1,
      TONE_1400   = 2'd2,
      TONE_2300   = 2'd3
   } tone_type;

   // Configuration register set
   typedef struct packed {
      logic [15:0] number_gap_ms;
      logic [15:0] message_gap_ms;
      logic [9:0]  handshake_tone_ms;
      logic [9:0]  kissoff_pause_ms;
      logic [15:0] kissoff_ms;
   } cfg_type;

   // One result transaction
   typedef struct packed {
      logic [1:0]           tone_select;
      logic                 digit_valid;
      logic [3:0]           digit_value;
      logic                 message_valid;
      logic [MESSAGE_W-1:0] message_digits;
      logic [1:0]           stage;
   } result_type;

endpackage

`default_nettype wire

FILE: hdl/adrs_csr.sv
// Configuration registers of the alarm DTMF receiver sequencer.
`default_nettype none

module adrs_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_en,
   input  wire logic [adrs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [adrs_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output adrs_pkg::cfg_type                      cfg
);

   adrs_pkg::cfg_type cfg_ff;

   // Register file; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.number_gap_ms     <= adrs_pkg::NUMBER_GAP_RESET;
         cfg_ff.message_gap_ms    <= adrs_pkg::MESSAGE_GAP_RESET;
         cfg_ff.handshake_tone_ms <= adrs_pkg::HANDSHAKE_TONE_RESET;
         cfg_ff.kissoff_pause_ms  <= adrs_pkg::KISSOFF_PAUSE_RESET;
         cfg_ff.kissoff_ms        <= adrs_pkg::KISSOFF_RESET;
      end else if (csr_write_en) begin
         case (adrs_pkg::csr_index_type'(csr_index))
            adrs_pkg::CSR_NUMBER_GAP:     cfg_ff.number_gap_ms     <= csr_wdata;
            adrs_pkg::CSR_MESSAGE_GAP:    cfg_ff.message_gap_ms    <= csr_wdata;
            adrs_pkg::CSR_HANDSHAKE_TONE: cfg_ff.handshake_tone_ms <= csr_wdata[9:0];
            adrs_pkg::CSR_KISSOFF_PAUSE:  cfg_ff.kissoff_pause_ms  <= csr_wdata[9:0];
            adrs_pkg::CSR_KISSOFF:        cfg_ff.kissoff_ms        <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: hdl/adrs_seq.sv
// Sequencer state and the single-pass update logic for one decoder sample.
`default_nettype none

module adrs_seq #(
   parameter int DIGITS_PER_MESSAGE = adrs_pkg::DIGITS_PER_MESSAGE_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic              ms_tick,
   input  wire logic              tone_present,
   input  wire logic [3:0]        tone_code,
   input  wire adrs_pkg::cfg_type cfg,
   output adrs_pkg::result_type   result
);

   localparam int MSG_SHIFT = 4 * (16 - DIGITS_PER_MESSAGE);
   localparam logic [4:0] DIGITS_LAST = 5'(DIGITS_PER_MESSAGE);

   adrs_pkg::stage_type stage_ff, stage_in;
   adrs_pkg::phase_type phase_ff, phase_in;
   logic        armed_ff, armed_in;
   logic        ntmr_on_ff, ntmr_on_in;
   logic [15:0] ntmr_ff, ntmr_in;
   logic        mtmr_on_ff, mtmr_on_in;
   logic [15:0] mtmr_ff, mtmr_in;
   logic [4:0]  count_ff, count_in;
   logic [63:0] buf_ff, buf_in;
   logic [15:0] btmr_ff, btmr_in;

   logic        got, msg, reload_n, reload_m;
   logic [63:0] msg_bits;
   logic [1:0]  tone;
   logic [1:0]  stage_out;

   // Update for one sample, in decoder, busy, then timer order
   always_comb begin
      stage_in   = stage_ff;
      phase_in   = phase_ff;
      armed_in   = armed_ff;
      ntmr_on_in = ntmr_on_ff;
      ntmr_in    = ntmr_ff;
      mtmr_on_in = mtmr_on_ff;
      mtmr_in    = mtmr_ff;
      count_in   = count_ff;
      buf_in     = buf_ff;
      btmr_in    = btmr_ff;
      got        = 1'b0;
      msg        = 1'b0;
      reload_n   = 1'b0;
      reload_m   = 1'b0;
      msg_bits   = '0;

      if (phase_ff != adrs_pkg::PH_IDLE) begin
         // busy: decoder ignored, phase timer runs
         if (ms_tick) begin
            if (btmr_ff != 16'd0) btmr_in = btmr_ff - 16'd1;
            if (btmr_in == 16'd0) begin
               case (phase_ff)
                  adrs_pkg::PH_HS_LOW: begin
                     phase_in = adrs_pkg::PH_HS_HIGH;
                     btmr_in  = {6'd0, cfg.handshake_tone_ms};
                  end
                  adrs_pkg::PH_HS_HIGH: begin
                     phase_in = adrs_pkg::PH_IDLE;
                     stage_in = adrs_pkg::ST_COLLECT;
                  end
                  adrs_pkg::PH_PAUSE: begin
                     phase_in = adrs_pkg::PH_KISS;
                     btmr_in  = cfg.kissoff_ms;
                  end
                  default: phase_in = adrs_pkg::PH_IDLE;
               endcase
            end
         end
      end else begin
         // rising edge of tone-present with a nonzero code
         if (!tone_present) begin
            armed_in = 1'b1;
         end else if (armed_ff && tone_code != 4'd0) begin
            armed_in = 1'b0;
            got      = 1'b1;
         end
         if (got && stage_ff == adrs_pkg::ST_LISTEN) begin
            ntmr_on_in = 1'b1;
            ntmr_in    = cfg.number_gap_ms;
            reload_n   = 1'b1;
         end else if (got && stage_ff == adrs_pkg::ST_COLLECT) begin
            mtmr_on_in = 1'b1;
            mtmr_in    = cfg.message_gap_ms;
            reload_m   = 1'b1;
            buf_in     = {buf_ff[59:0],
                          (tone_code == adrs_pkg::DIGIT_ZERO_CODE) ? 4'd0 : tone_code};
            count_in   = count_ff + 5'd1;
            if (count_in >= DIGITS_LAST) begin
               msg      = 1'b1;
               msg_bits = buf_in << MSG_SHIFT;
               buf_in   = '0;
               count_in = '0;
               if (cfg.kissoff_pause_ms != 10'd0) begin
                  phase_in = adrs_pkg::PH_PAUSE;
                  btmr_in  = {6'd0, cfg.kissoff_pause_ms};
               end else begin
                  phase_in = adrs_pkg::PH_KISS;
                  btmr_in  = cfg.kissoff_ms;
               end
            end
         end
      end

      // number gap timer: fires once more than the gap has passed
      if (ntmr_on_ff && ms_tick && !reload_n) begin
         if (ntmr_ff == 16'd0) begin
            ntmr_on_in = 1'b0;
            stage_in   = adrs_pkg::ST_HANDSHAKE;
            phase_in   = adrs_pkg::PH_HS_LOW;
            btmr_in    = {6'd0, cfg.handshake_tone_ms};
         end else begin
            ntmr_in = ntmr_ff - 16'd1;
         end
      end

      // message gap timer: back to listen
      if (mtmr_on_ff && ms_tick && !reload_m) begin
         if (mtmr_ff == 16'd0) begin
            mtmr_on_in = 1'b0;
            stage_in   = adrs_pkg::ST_LISTEN;
         end else begin
            mtmr_in = mtmr_ff - 16'd1;
         end
      end
   end

   // Tone and visible stage from the updated state
   always_comb begin
      case (phase_in)
         adrs_pkg::PH_HS_LOW:  tone = adrs_pkg::TONE_1400;
         adrs_pkg::PH_HS_HIGH: tone = adrs_pkg::TONE_2300;
         adrs_pkg::PH_PAUSE:   tone = adrs_pkg::TONE_SILENT;
         adrs_pkg::PH_KISS:    tone = adrs_pkg::TONE_1400;
         default: tone = (stage_in == adrs_pkg::ST_LISTEN) ? adrs_pkg::TONE_300
                                                            : adrs_pkg::TONE_SILENT;
      endcase
      if (phase_in == adrs_pkg::PH_PAUSE || phase_in == adrs_pkg::PH_KISS) begin
         stage_out = adrs_pkg::ST_BUSY_OUT;
      end else begin
         stage_out = stage_in;
      end
   end

   assign result.tone_select    = tone;
   assign result.digit_valid    = got;
   assign result.digit_value    = got ? tone_code : 4'd0;
   assign result.message_valid  = msg;
   assign result.message_digits = msg_bits;
   assign result.stage          = stage_out;

   // State registers, advanced once per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff   <= adrs_pkg::ST_LISTEN;
         phase_ff   <= adrs_pkg::PH_IDLE;
         armed_ff   <= 1'b1;
         ntmr_on_ff <= 1'b0;
         ntmr_ff    <= '0;
         mtmr_on_ff <= 1'b0;
         mtmr_ff    <= '0;
         count_ff   <= '0;
         buf_ff     <= '0;
         btmr_ff    <= '0;
      end else if (step) begin
         stage_ff   <= stage_in;
         phase_ff   <= phase_in;
         armed_ff   <= armed_in;
         ntmr_on_ff <= ntmr_on_in;
         ntmr_ff    <= ntmr_in;
         mtmr_on_ff <= mtmr_on_in;
         mtmr_ff    <= mtmr_in;
         count_ff   <= count_in;
         buf_ff     <= buf_in;
         btmr_ff    <= btmr_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/alarm_dtmf_receiver_sequencer.sv
// Top level of the alarm DTMF receiver sequencer: input and result registers.
//
//   Channel  Direction  Handshake                  Payload
//   req      in         req_valid / req_ready      ms_tick, tone_present, tone_code
//   rsp      out        rsp_valid / rsp_ready      tone_select, digit_*, message_*, stage
//   csr      in         csr_write_en               csr_index, csr_wdata
//
// One transaction per cycle sustained while rsp_ready stays high; each sample goes input
// register -> update logic -> result register.
// Reset is synchronous and clears the valid flags of both registers and the sequencer state.
// A stalled result holds the input register; req_ready stays high while
// the result register is empty or being taken.
`default_nettype none

module alarm_dtmf_receiver_sequencer #(
   parameter int DIGITS_PER_MESSAGE = adrs_pkg::DIGITS_PER_MESSAGE_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_ms_tick,
   input  wire logic                              req_tone_present,
   input  wire logic [3:0]                        req_tone_code,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [1:0]                             rsp_tone_select,
   output logic                                   rsp_digit_valid,
   output logic [3:0]                             rsp_digit_value,
   output logic                                   rsp_message_valid,
   output logic [adrs_pkg::MESSAGE_W-1:0]         rsp_message_digits,
   output logic [1:0]                             rsp_stage,
   input  wire logic                              csr_write_en,
   input  wire logic [adrs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [adrs_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   adrs_pkg::cfg_type    cfg;
   adrs_pkg::result_type result;
   adrs_pkg::result_type rsp_ff;

   logic       in_valid_ff;
   logic       in_tick_ff;
   logic       in_present_ff;
   logic [3:0] in_code_ff;
   logic       rsp_valid_ff;
   logic       advance;

   // Pipeline control
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   adrs_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   adrs_seq #(
      .DIGITS_PER_MESSAGE (DIGITS_PER_MESSAGE)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .ms_tick      (in_tick_ff),
      .tone_present (in_present_ff),
      .tone_code    (in_code_ff),
      .cfg          (cfg),
      .result       (result)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_tick_ff    <= req_ms_tick;
         in_present_ff <= req_tone_present;
         in_code_ff    <= req_tone_code;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_tone_select    = rsp_ff.tone_select;
   assign rsp_digit_valid    = rsp_ff.digit_valid;
   assign rsp_digit_value    = rsp_ff.digit_value;
   assign rsp_message_valid  = rsp_ff.message_valid;
   assign rsp_message_digits = rsp_ff.message_digits;
   assign rsp_stage          = rsp_ff.stage;

endmodule

`default_nettype wire

FILE: hdl/adrs_checker.sv
// Port-level checks for the alarm DTMF receiver sequencer, bound to the top level.
`default_nettype none

module adrs_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [1:0]                        rsp_tone_select,
   input wire logic                              rsp_digit_valid,
   input wire logic [3:0]                        rsp_digit_value,
   input wire logic                              rsp_message_valid,
   input wire logic [adrs_pkg::MESSAGE_W-1:0]    rsp_message_digits,
   input wire logic [1:0]                        rsp_stage
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_stage)
         && $stable(rsp_tone_select) && $stable(rsp_message_digits))
      else $error("result changed while stalled");

   // Digit value is zero unless a digit was taken
   a_digit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_digit_valid |-> rsp_digit_value == 4'd0)
      else $error("digit value without digit");

   // Message bits are zero unless a message completed
   a_msg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_message_valid |-> rsp_message_digits == '0)
      else $error("message bits without message");

   // A completed message comes with its last digit and starts the kissoff stage
   a_msg_kiss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_valid |-> rsp_digit_valid
         && rsp_stage == adrs_pkg::ST_BUSY_OUT)
      else $error("message without digit or kissoff");

   // Handshake stage always plays one of the handshake tones
   a_hs_tone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stage == adrs_pkg::ST_HANDSHAKE |->
         rsp_tone_select == adrs_pkg::TONE_1400 || rsp_tone_select == adrs_pkg::TONE_2300)
      else $error("handshake stage without handshake tone");

endmodule

bind alarm_dtmf_receiver_sequencer adrs_checker u_adrs_checker (.*);

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking testbench for the alarm DTMF receiver sequencer: predictor, scoreboard, stimulus.
`default_nettype none

// Tracks the sequencer state per accepted sample and checks each result transaction in order
class dtmf_scoreboard;
   localparam int DIGITS = adrs_pkg::DIGITS_PER_MESSAGE_DEFAULT;

   // register copy
   logic [15:0] number_gap;
   logic [15:0] message_gap;
   logic [9:0]  handshake_len;
   logic [9:0]  pause_len;
   logic [15:0] kissoff_len;

   // sequencer copy
   adrs_pkg::stage_type stage_q;
   adrs_pkg::phase_type phase;
   bit          armed;
   bit          num_on;
   logic [15:0] num_left;
   bit          msg_on;
   logic [15:0] msg_left;
   logic [4:0]  count;
   logic [63:0] buffer;
   logic [15:0] busy_left;

   adrs_pkg::result_type pending[$];
   int          mismatches;
   int          samples;
   int          digits;
   int          messages;
   logic [3:0]  stages_seen;

   function new();
      number_gap    = adrs_pkg::NUMBER_GAP_RESET;
      message_gap   = adrs_pkg::MESSAGE_GAP_RESET;
      handshake_len = adrs_pkg::HANDSHAKE_TONE_RESET;
      pause_len     = adrs_pkg::KISSOFF_PAUSE_RESET;
      kissoff_len   = adrs_pkg::KISSOFF_RESET;
      stage_q       = adrs_pkg::ST_LISTEN;
      phase         = adrs_pkg::PH_IDLE;
      armed         = 1'b1;
      num_on        = 1'b0;
      num_left      = '0;
      msg_on        = 1'b0;
      msg_left      = '0;
      count         = '0;
      buffer        = '0;
      busy_left     = '0;
      mismatches    = 0;
      samples       = 0;
      digits        = 0;
      messages      = 0;
      stages_seen   = '0;
   endfunction

   // 10-bit registers keep only their low bits
   function void set_reg(adrs_pkg::csr_index_type idx, logic [15:0] value);
      case (idx)
         adrs_pkg::CSR_NUMBER_GAP:     number_gap    = value;
         adrs_pkg::CSR_MESSAGE_GAP:    message_gap   = value;
         adrs_pkg::CSR_HANDSHAKE_TONE: handshake_len = value[9:0];
         adrs_pkg::CSR_KISSOFF_PAUSE:  pause_len     = value[9:0];
         adrs_pkg::CSR_KISSOFF:        kissoff_len   = value;
         default: ;
      endcase
   endfunction

   // Timed phase ran out
   function void end_phase();
      case (phase)
         adrs_pkg::PH_HS_LOW: begin
            phase     = adrs_pkg::PH_HS_HIGH;
            busy_left = {6'd0, handshake_len};
         end
         adrs_pkg::PH_HS_HIGH: begin
            phase   = adrs_pkg::PH_IDLE;
            stage_q = adrs_pkg::ST_COLLECT;
         end
         adrs_pkg::PH_PAUSE: begin
            phase     = adrs_pkg::PH_KISS;
            busy_left = kissoff_len;
         end
         default: phase = adrs_pkg::PH_IDLE;
      endcase
   endfunction

   function int outstanding();
      return pending.size();
   endfunction

   // One accepted input transaction -> one expected result
   function void note_sample(bit tick, bit present, logic [3:0] code);
      bit                   got;
      bit                   msg;
      bit                   num_reload;
      bit                   msg_reload;
      logic [63:0]          msg_bits;
      adrs_pkg::tone_type   tone;
      adrs_pkg::result_type exp;
      got        = 1'b0;
      msg        = 1'b0;
      num_reload = 1'b0;
      msg_reload = 1'b0;
      msg_bits   = '0;

      if (phase != adrs_pkg::PH_IDLE) begin
         // decoder ignored while a timed phase runs
         if (tick) begin
            if (busy_left != 16'd0) busy_left = busy_left - 16'd1;
            if (busy_left == 16'd0) end_phase();
         end
      end else begin
         // rising edge of tone-present with a nonzero code takes a digit
         if (!present) armed = 1'b1;
         else if (armed && code != 4'd0) begin
            armed = 1'b0;
            got   = 1'b1;
         end
         if (got && stage_q == adrs_pkg::ST_LISTEN) begin
            num_on     = 1'b1;
            num_left   = number_gap;
            num_reload = 1'b1;
         end else if (got && stage_q == adrs_pkg::ST_COLLECT) begin
            msg_on     = 1'b1;
            msg_left   = message_gap;
            msg_reload = 1'b1;
            buffer     = {buffer[59:0], (code == adrs_pkg::DIGIT_ZERO_CODE) ? 4'd0 : code};
            count      = count + 5'd1;
            if (count >= 5'(DIGITS)) begin
               msg      = 1'b1;
               msg_bits = buffer << (4 * (16 - DIGITS));
               buffer   = '0;
               count    = '0;
               if (pause_len != 10'd0) begin
                  phase     = adrs_pkg::PH_PAUSE;
                  busy_left = {6'd0, pause_len};
               end else begin
                  phase     = adrs_pkg::PH_KISS;
                  busy_left = kissoff_len;
               end
            end
         end
      end

      // number gap expiry starts the handshake
      if (num_on && tick && !num_reload) begin
         if (num_left == 16'd0) begin
            num_on    = 1'b0;
            stage_q   = adrs_pkg::ST_HANDSHAKE;
            phase     = adrs_pkg::PH_HS_LOW;
            busy_left = {6'd0, handshake_len};
         end else begin
            num_left = num_left - 16'd1;
         end
      end
      // message gap expiry drops back to listen, even mid-kissoff
      if (msg_on && tick && !msg_reload) begin
         if (msg_left == 16'd0) begin
            msg_on  = 1'b0;
            stage_q = adrs_pkg::ST_LISTEN;
         end else begin
            msg_left = msg_left - 16'd1;
         end
      end

      case (phase)
         adrs_pkg::PH_HS_LOW:  tone = adrs_pkg::TONE_1400;
         adrs_pkg::PH_HS_HIGH: tone = adrs_pkg::TONE_2300;
         adrs_pkg::PH_PAUSE:   tone = adrs_pkg::TONE_SILENT;
         adrs_pkg::PH_KISS:    tone = adrs_pkg::TONE_1400;
         default: tone = (stage_q == adrs_pkg::ST_LISTEN) ? adrs_pkg::TONE_300
                                                          : adrs_pkg::TONE_SILENT;
      endcase

      exp.tone_select    = tone;
      exp.digit_valid    = got;
      exp.digit_value    = got ? code : 4'd0;
      exp.message_valid  = msg;
      exp.message_digits = msg_bits;
      exp.stage          = (phase == adrs_pkg::PH_PAUSE || phase == adrs_pkg::PH_KISS)
                           ? adrs_pkg::ST_BUSY_OUT : stage_q;
      pending.push_back(exp);

      samples++;
      if (got) digits++;
      if (msg) messages++;
      stages_seen[exp.stage] = 1'b1;
   endfunction

   function void compare(string field, logic [63:0] expected, logic [63:0] actual);
      if (expected !== actual) begin
         $error("%s mismatch: expected %0h, got %0h", field, expected, actual);
         mismatches++;
      end
   endfunction

   function void check_result(adrs_pkg::result_type actual);
      adrs_pkg::result_type exp;
      if (pending.size() == 0) begin
         $error("result transaction with nothing expected");
         mismatches++;
         return;
      end
      exp = pending.pop_front();
      compare("tone_select", 64'(exp.tone_select), 64'(actual.tone_select));
      compare("digit_valid", 64'(exp.digit_valid), 64'(actual.digit_valid));
      compare("digit_value", 64'(exp.digit_value), 64'(actual.digit_value));
      compare("message_valid", 64'(exp.message_valid), 64'(actual.message_valid));
      compare("message_digits", exp.message_digits, actual.message_digits);
      compare("stage", 64'(exp.stage), 64'(actual.stage));
   endfunction
endclass

module tb_top;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 80;
   localparam int HOLD_AT     = 120;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic                             req_ms_tick;
   logic                             req_tone_present;
   logic [3:0]                       req_tone_code;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic [1:0]                       rsp_tone_select;
   logic                             rsp_digit_valid;
   logic [3:0]                       rsp_digit_value;
   logic                             rsp_message_valid;
   logic [adrs_pkg::MESSAGE_W-1:0]   rsp_message_digits;
   logic [1:0]                       rsp_stage;
   logic                             csr_write_en;
   logic [adrs_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [adrs_pkg::CSR_DATA_W-1:0]  csr_wdata;

   dtmf_scoreboard sb;
   bit             steady;   // both sides stop idling while set
   int             cycles;

   alarm_dtmf_receiver_sequencer u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_ms_tick        (req_ms_tick),
      .req_tone_present   (req_tone_present),
      .req_tone_code      (req_tone_code),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_tone_select    (rsp_tone_select),
      .rsp_digit_valid    (rsp_digit_valid),
      .rsp_digit_value    (rsp_digit_value),
      .rsp_message_valid  (rsp_message_valid),
      .rsp_message_digits (rsp_message_digits),
      .rsp_stage          (rsp_stage),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // Result side: random back-pressure plus one long hold-off
   initial begin
      int  taken;
      int  hold_left;
      bit  held_once;
      taken     = 0;
      hold_left = 0;
      held_once = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            sb.check_result({rsp_tone_select, rsp_digit_valid, rsp_digit_value,
                             rsp_message_valid, rsp_message_digits, rsp_stage});
            taken++;
         end
         if (taken == HOLD_AT && !held_once) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!steady && $urandom_range(99) < 31) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offer one decoder sample and wait for the handshake
   task automatic send_sample(input bit tick, input bit present, input logic [3:0] code);
      while (!steady && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_ms_tick      <= tick;
      req_tone_present <= present;
      req_tone_code    <= code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_sample(tick, present, code);
   endtask

   // Stop offering and let every expected result drain out
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input adrs_pkg::csr_index_type idx, input logic [15:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   task automatic program_regs(input logic [15:0] ngap, input logic [15:0] mgap,
                               input logic [15:0] hs, input logic [15:0] pause,
                               input logic [15:0] kiss);
      write_reg(adrs_pkg::CSR_NUMBER_GAP, ngap);
      write_reg(adrs_pkg::CSR_MESSAGE_GAP, mgap);
      write_reg(adrs_pkg::CSR_HANDSHAKE_TONE, hs);
      write_reg(adrs_pkg::CSR_KISSOFF_PAUSE, pause);
      write_reg(adrs_pkg::CSR_KISSOFF, kiss);
      csr_write_en <= 1'b0;
   endtask

   // Mostly key presses (tone burst then silence, sometimes a long one), some noise
   task automatic random_samples(input int count, input int tick_pct);
      int         left;
      int         burst;
      int         quiet;
      logic [3:0] code;
      left = count;
      while (left > 0) begin
         if ($urandom_range(99) < 12) begin
            send_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                        4'($urandom_range(15)));
            left--;
         end else begin
            code  = 4'($urandom_range(15));
            burst = $urandom_range(1, 3);
            quiet = ($urandom_range(99) < 15) ? $urandom_range(8, 40) : $urandom_range(1, 3);
            repeat (burst) begin
               send_sample($urandom_range(99) < tick_pct, 1'b1, code);
               left--;
            end
            repeat (quiet) begin
               send_sample($urandom_range(99) < tick_pct, 1'b0, 4'($urandom_range(15)));
               left--;
            end
         end
      end
   endtask

   initial begin
      sb               = new();
      steady           = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_ms_tick      = 1'b0;
      req_tone_present = 1'b0;
      req_tone_code    = 4'd0;
      csr_write_en     = 1'b0;
      csr_index        = adrs_pkg::CSR_NUMBER_GAP;
      csr_wdata        = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: edge detect, zero code ignored while armed, digit zero, code extremes
      send_sample(1'b0, 1'b0, 4'd0);
      send_sample(1'b1, 1'b1, 4'd0);
      send_sample(1'b0, 1'b1, 4'd15);
      send_sample(1'b1, 1'b1, 4'd15);
      send_sample(1'b0, 1'b1, 4'd7);
      send_sample(1'b1, 1'b0, 4'd15);
      send_sample(1'b0, 1'b1, adrs_pkg::DIGIT_ZERO_CODE);
      send_sample(1'b0, 1'b0, adrs_pkg::DIGIT_ZERO_CODE);
      send_sample(1'b1, 1'b1, 4'd1);
      send_sample(1'b1, 1'b0, 4'd0);
      send_sample(1'b1, 1'b1, 4'd8);
      send_sample(1'b0, 1'b0, 4'd8);
      send_sample(1'b1, 1'b1, 4'd4);
      send_sample(1'b1, 1'b1, 4'd0);
      send_sample(1'b0, 1'b0, 4'd0);
      send_sample(1'b1, 1'b1, 4'd2);
      send_sample(1'b1, 1'b0, 4'd2);
      send_sample(1'b0, 1'b1, 4'd5);
      send_sample(1'b1, 1'b0, 4'd11);
      send_sample(1'b1, 1'b1, 4'd0);
      send_sample(1'b0, 1'b1, 4'd12);
      send_sample(1'b1, 1'b0, 4'd0);
      settle();

      // Short timers so the full handshake/message/kissoff cycle comes round
      program_regs(16'd3, 16'd25, 16'd2, 16'd2, 16'd4);
      random_samples(130, 45);
      settle();

      // Low extremes, zero pause skips straight to kissoff; no idling here
      steady = 1'b1;
      program_regs(16'd1, 16'd1, 16'd1, 16'd0, 16'd1);
      random_samples(100, 15);
      settle();
      steady = 1'b0;

      // Upper bits on the 10-bit registers must be dropped
      program_regs(16'd5, 16'd40, 16'hFC03, 16'h0401, 16'd6);
      random_samples(100, 50);
      settle();

      // High extremes
      program_regs(16'hFFFF, 16'hFFFF, 16'd1023, 16'd1023, 16'hFFFF);
      random_samples(60, 50);
      settle();

      $display("Covered %0d samples, %0d digits, %0d full messages; stages seen %b",
               sb.samples, sb.digits, sb.messages, sb.stages_seen);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

`default_nettype wire

FILE: filelist.f
hdl/adrs_pkg.sv
hdl/adrs_csr.sv
hdl/adrs_seq.sv
hdl/alarm_dtmf_receiver_sequencer.sv
hdl/adrs_checker.sv
bench/tb_top.sv
